[design/assert_macros.svh]
// Assertion macros shared by the CSV tokenizer RTL.
// Each macro expands to one labeled concurrent assertion clocked on a rising edge.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every clock edge while out of reset.
`define ASSERT_ALWAYS(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[design/csvt_pkg.sv]
// Package for the CSV stream tokenizer: request and result types, kind codes,
// character constants and the parser step struct. No dependencies.
package csvt_pkg;

	localparam int LEN_W = 13;
	localparam int COL_W = 16;
	localparam int ROW_W = 32;

	localparam logic [LEN_W-1:0] MAX_LEN_RESET = 13'd4096;

	localparam logic [1:0] KIND_CHAR      = 2'd0;
	localparam logic [1:0] KIND_FIELD_END = 2'd1;
	localparam logic [1:0] KIND_ERROR     = 2'd2;
	localparam logic [1:0] KIND_DONE      = 2'd3;

	localparam logic CMD_BYTE = 1'b0;
	localparam logic CMD_END  = 1'b1;

	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_COMMA = 8'h2C;
	localparam logic [7:0] CH_QUOTE = 8'h22;

	typedef struct packed {
		logic       command;
		logic [7:0] in_byte;
	} in_item_t;

	typedef struct packed {
		logic [1:0]       kind;
		logic [7:0]       data_char;
		logic [ROW_W-1:0] row_index;
		logic [COL_W-1:0] col_index;
		logic [LEN_W-1:0] field_length;
		logic             row_ends;
	} out_item_t;

	// What the parser hands to the output stage for one request.
	typedef struct packed {
		logic      has_result;
		out_item_t item;
	} step_t;

endpackage

[design/csvt_in_stage.sv]
// Input register of the CSV tokenizer: holds one request until the parser takes it.
// Depends on csvt_pkg.
`include "assert_macros.svh"

module csvt_in_stage (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  csvt_pkg::in_item_t in_data,
	input  logic              advance,
	output logic              valid_s1,
	output csvt_pkg::in_item_t data_s1
);
	import csvt_pkg::*;

	logic accept;

	// The held request leaves in the same cycle a new one may enter.
	assign in_stall = valid_s1 && !advance;
	assign accept   = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			data_s1 <= in_data;
		end
	end

	`ASSERT_IMPLIES(a_adv_needs_item, clk, arst_n, advance, valid_s1,
		"parser advanced with no request held")

endmodule

[design/csvt_parser.sv]
// Parse state, counters and the combinational step logic of the CSV tokenizer.
// Depends on csvt_pkg.
`include "assert_macros.svh"

module csvt_parser #(
	parameter int FIELD_MAX = 4096
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         take,
	input  csvt_pkg::in_item_t           item_s1,
	input  logic [csvt_pkg::LEN_W-1:0]   max_len,
	output csvt_pkg::step_t              step
);
	import csvt_pkg::*;

	typedef enum logic [2:0] {
		ST_START      = 3'd0,
		ST_QUOTED     = 3'd1,
		ST_QUOTE_SEEN = 3'd2,
		ST_PLAIN      = 3'd3,
		ST_AFTER_CR   = 3'd4,
		ST_ERROR      = 3'd5
	} pstate_t;

	// The length counter never passes the register's range, so a larger cap is moot.
	localparam int LEN_CAP_I = (FIELD_MAX > (2**LEN_W - 1)) ? (2**LEN_W - 1) : FIELD_MAX;
	localparam logic [LEN_W-1:0] LEN_CAP = LEN_CAP_I[LEN_W-1:0];

	pstate_t           state_q, state_d, plain_state;
	pstate_t           state_next;
	logic [ROW_W-1:0]  row_q, row_d;
	logic [COL_W-1:0]  col_q, col_d;
	logic [LEN_W-1:0]  len_q, len_d;
	logic [LEN_W-1:0]  limit;
	logic [7:0]        ch;
	logic              do_end, end_row, do_char, do_fail, do_done;
	logic              plain_end, plain_row, plain_char;

	assign ch    = item_s1.in_byte;
	assign limit = (max_len < LEN_CAP) ? max_len : LEN_CAP;

	// Handling of a byte outside quotes, shared by several states.
	always_comb begin
		plain_state = ST_PLAIN;
		plain_end   = 1'b0;
		plain_row   = 1'b0;
		plain_char  = 1'b0;
		case (ch)
			CH_CR:    plain_state = ST_AFTER_CR;
			CH_LF: begin
				plain_end = 1'b1;
				plain_row = 1'b1;
			end
			CH_QUOTE: plain_state = ST_QUOTED;
			CH_COMMA: plain_end = 1'b1;
			default:  plain_char = 1'b1;
		endcase
	end

	// Decide which action this request takes.
	always_comb begin
		state_d = state_q;
		do_end  = 1'b0;
		end_row = 1'b0;
		do_char = 1'b0;
		do_fail = 1'b0;
		do_done = 1'b0;
		if (item_s1.command == CMD_END) begin
			unique case (state_q)
				ST_START:                do_done = 1'b1;
				ST_PLAIN, ST_QUOTE_SEEN: do_end  = 1'b1;
				default:                 do_fail = 1'b1;
			endcase
		end else begin
			unique case (state_q)
				ST_START, ST_PLAIN: begin
					if (state_q == ST_START && ch == CH_QUOTE) begin
						state_d = ST_QUOTED;
					end else begin
						state_d = plain_state;
						do_end  = plain_end;
						end_row = plain_row;
						do_char = plain_char;
					end
				end
				ST_QUOTED: begin
					if (ch == CH_QUOTE) begin
						state_d = ST_QUOTE_SEEN;
					end else begin
						do_char = 1'b1;
					end
				end
				ST_QUOTE_SEEN: begin
					if (ch == CH_QUOTE) begin
						state_d = ST_QUOTED;
						do_char = 1'b1;
					end else begin
						state_d = plain_state;
						do_end  = plain_end;
						end_row = plain_row;
						do_char = plain_char;
					end
				end
				ST_AFTER_CR: begin
					if (ch == CH_LF) begin
						do_end  = 1'b1;
						end_row = 1'b1;
					end else begin
						do_fail = 1'b1;
					end
				end
				default: do_fail = 1'b1;
			endcase
		end
	end

	// Carry out the action: result fields and counter updates.
	always_comb begin
		pstate_t nxt;
		nxt   = state_d;
		row_d = row_q;
		col_d = col_q;
		len_d = len_q;
		step.has_result        = 1'b0;
		step.item.kind         = KIND_CHAR;
		step.item.data_char    = 8'd0;
		step.item.row_index    = row_q;
		step.item.col_index    = col_q;
		step.item.field_length = '0;
		step.item.row_ends     = 1'b0;
		if (do_fail || (do_char && len_q >= limit)) begin
			nxt             = ST_ERROR;
			step.has_result = 1'b1;
			step.item.kind  = KIND_ERROR;
		end else if (do_char) begin
			len_d                  = len_q + 1'b1;
			step.has_result        = 1'b1;
			step.item.data_char    = ch;
			step.item.field_length = len_q + 1'b1;
		end else if (do_end) begin
			nxt                    = ST_START;
			len_d                  = '0;
			step.has_result        = 1'b1;
			step.item.kind         = KIND_FIELD_END;
			step.item.field_length = len_q;
			step.item.row_ends     = end_row;
			if (end_row) begin
				col_d = '0;
				if (row_q != '1) begin
					row_d = row_q + 1'b1;
				end
			end else if (col_q != '1) begin
				col_d = col_q + 1'b1;
			end
		end else if (do_done) begin
			step.has_result = 1'b1;
			step.item.kind  = KIND_DONE;
		end
		state_next = nxt;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_START;
			row_q   <= '0;
			col_q   <= '0;
			len_q   <= '0;
		end else if (take) begin
			state_q <= state_next;
			row_q   <= row_d;
			col_q   <= col_d;
			len_q   <= len_d;
		end
	end

	`ASSERT_NEXT(a_error_sticky, clk, arst_n, state_q == ST_ERROR, state_q == ST_ERROR,
		"parser left the error state")
	`ASSERT_NEXT(a_row_end_clears_col, clk, arst_n,
		take && step.has_result && step.item.kind == KIND_FIELD_END && step.item.row_ends,
		col_q == '0, "column not cleared after a row end")

endmodule

[design/csvt_out_stage.sv]
// Result register of the CSV tokenizer, drained by the downstream side.
// Depends on csvt_pkg.
`include "assert_macros.svh"

module csvt_out_stage (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               load,
	input  csvt_pkg::out_item_t item,
	output logic               free,
	output logic               out_valid,
	input  logic               out_stall,
	output csvt_pkg::out_item_t out_data
);
	import csvt_pkg::*;

	logic      valid_s2;
	out_item_t data_s2;

	assign free      = !valid_s2 || !out_stall;
	assign out_valid = valid_s2;
	assign out_data  = data_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (load) begin
			valid_s2 <= 1'b1;
		end else if (!out_stall) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			data_s2 <= item;
		end
	end

	`ASSERT_IMPLIES(a_no_overwrite, clk, arst_n, valid_s2 && out_stall, !load,
		"result register loaded while its result waits")

endmodule

[design/csv_stream_tokenizer_unit.sv]
// CSV stream tokenizer: one byte or end-of-input request in, at most one result out.
// A request is held in the input register; its result, if any, then in the result register.
// Throughput: one request per cycle while out_stall is low, as the parse state and counters update per request.
// Reset clears the parse state, row, column and length counters and the handshake
// valids, and returns the field length limit register to 4096; no clearing pass.
`include "assert_macros.svh"

module csv_stream_tokenizer_unit #(
	parameter int FIELD_MAX = 4096
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  csvt_pkg::in_item_t         in_data,
	output logic                       out_valid,
	input  logic                       out_stall,
	output csvt_pkg::out_item_t        out_data,
	input  logic                       cfg_write,
	input  logic [csvt_pkg::LEN_W-1:0] cfg_data
);
	import csvt_pkg::*;

	logic [LEN_W-1:0] max_field_len_q;
	logic             valid_s1;
	in_item_t         data_s1;
	logic             free;
	logic             advance;
	step_t            step;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_field_len_q <= MAX_LEN_RESET;
		end else if (cfg_write) begin
			max_field_len_q <= cfg_data;
		end
	end

	assign advance = valid_s1 && free;

	csvt_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_data  (in_data),
		.advance  (advance),
		.valid_s1 (valid_s1),
		.data_s1  (data_s1)
	);

	csvt_parser #(
		.FIELD_MAX (FIELD_MAX)
	) u_parser (
		.clk     (clk),
		.arst_n  (arst_n),
		.take    (advance),
		.item_s1 (data_s1),
		.max_len (max_field_len_q),
		.step    (step)
	);

	csvt_out_stage u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (advance && step.has_result),
		.item      (step.item),
		.free      (free),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

endmodule
